// ===== design/assert_macros.svh =====
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition is followed by another one in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/y2r_pkg.sv =====
// Shared types, constants and helpers for the YUYV to RGB888 converter.
package y2r_pkg;

    typedef logic [1:0] t_mode;

    localparam t_mode MODE_ITU_Q14   = 2'd0;
    localparam t_mode MODE_ITU_SHIFT = 2'd1;
    localparam t_mode MODE_NTSC      = 2'd2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_px;

    // Q14 coefficients
    localparam logic signed [24:0] Q14_RED_CR   = 25'sd22970;
    localparam logic signed [24:0] Q14_GREEN_CB = 25'sd5636;
    localparam logic signed [24:0] Q14_GREEN_CR = 25'sd11698;
    localparam logic signed [24:0] Q14_BLUE_CB  = 25'sd29032;

    // Studio-range coefficients
    localparam logic signed [19:0] NTSC_Y      = 20'sd298;
    localparam logic signed [19:0] NTSC_R_CR   = 20'sd409;
    localparam logic signed [19:0] NTSC_G_CB   = 20'sd100;
    localparam logic signed [19:0] NTSC_G_CR   = 20'sd208;
    localparam logic signed [19:0] NTSC_B_CB   = 20'sd516;
    localparam logic signed [19:0] NTSC_Y_OFS  = 20'sd16;
    localparam logic signed [19:0] NTSC_ROUND  = 20'sd128;

    localparam logic signed [8:0]  CHROMA_OFS  = 9'sd128;
    localparam logic [7:0]         PIX_MAX     = 8'hFF;

    // Clamp a signed intermediate to 0..255.
    function automatic logic [7:0] clip8(input logic signed [19:0] x);
        logic [7:0] res;
        if (x <= 20'sd0) begin
            res = 8'd0;
        end else if (x >= 20'sd255) begin
            res = PIX_MAX;
        end else begin
            res = x[7:0];
        end
        return res;
    endfunction

    // Floor a non-negative Q14 sum and saturate; negative sums give zero.
    function automatic logic [7:0] q14_clip(input logic signed [24:0] sum);
        logic [7:0] res;
        if (sum[24]) begin
            res = 8'd0;
        end else if (sum[23:14] > 10'd255) begin
            res = PIX_MAX;
        end else begin
            res = sum[21:14];
        end
        return res;
    endfunction

endpackage

// ===== design/yuyv422_to_rgb888_top.sv =====
// Top level of the YUYV 4:2:2 to RGB888 converter.
// Each YUYV group accepted on start (while busy is low) yields two RGB pixels on o_strobe,
// first pixel then second, in consecutive cycles. The group is registered in the input
// stage, and its first pixel then in the output merge stage; the group waits in the input
// stage while the previous group's second pixel is sent, as in a back-to-back stream.
// Both lanes convert a group's pixels at once; the single pixel output port sends them one
// at a time while the input stage can hold the next group; busy rises only while a group is
// waiting behind a second pixel still to be sent. The receiver cannot stall: each pixel is
// present for exactly one cycle. The mode register may be written only while idle.
`include "assert_macros.svh"

module yuyv422_to_rgb888_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_first_luma,
    input  logic [7:0] i_blue_diff,
    input  logic [7:0] i_second_luma,
    input  logic [7:0] i_red_diff,
    input  logic       i_frame_end,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data,
    output logic       o_strobe,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic       o_pixel_slot,
    output logic       o_run_last,
    output logic       o_frame_last
);
    import y2r_pkg::*;

    t_mode      r_mode;
    logic       r_s1_valid;
    logic [7:0] r_y0, r_y1, r_cb, r_cr;
    logic       r_fend;
    logic       accept;
    logic       take;
    t_px        px0, px1, px_out;

    assign o_cfg_ready = 1'b1;
    assign busy        = r_s1_valid && !take;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ITU_Q14;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    // Input stage: hold the group until the merge stage takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
            r_y0       <= i_first_luma;
            r_y1       <= i_second_luma;
            r_cb       <= i_blue_diff;
            r_cr       <= i_red_diff;
            r_fend     <= i_frame_end;
        end else if (take) begin
            r_s1_valid <= 1'b0;
        end
    end

    y2r_lane u_lane0 (
        .i_mode (r_mode),
        .i_luma (r_y0),
        .i_cb   (r_cb),
        .i_cr   (r_cr),
        .o_px   (px0)
    );

    y2r_lane u_lane1 (
        .i_mode (r_mode),
        .i_luma (r_y1),
        .i_cb   (r_cb),
        .i_cr   (r_cr),
        .o_px   (px1)
    );

    y2r_out_seq u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_s1_valid),
        .i_px0        (px0),
        .i_px1        (px1),
        .i_frame_end  (r_fend),
        .o_take       (take),
        .o_strobe     (o_strobe),
        .o_px         (px_out),
        .o_pixel_slot (o_pixel_slot),
        .o_run_last   (o_run_last),
        .o_frame_last (o_frame_last)
    );

    assign o_red   = px_out.red;
    assign o_green = px_out.green;
    assign o_blue  = px_out.blue;

    `ASSERT_NEXT(a_second_follows, i_clk, i_rst_n, o_strobe && !o_pixel_slot, o_strobe && o_pixel_slot)
    `ASSERT_CLK(a_slot_flags, i_clk, i_rst_n, !o_strobe || (o_run_last == o_pixel_slot))
    `ASSERT_CLK(a_frame_last_slot, i_clk, i_rst_n, !(o_strobe && o_frame_last) || o_pixel_slot)
    `ASSERT_NEXT(a_group_to_pixel, i_clk, i_rst_n, r_s1_valid && take, o_strobe && !o_pixel_slot)

endmodule

// ===== design/y2r_lane.sv =====
// One conversion lane: turns a luma sample and the shared chroma into one RGB pixel.
module y2r_lane (
    input  y2r_pkg::t_mode i_mode,
    input  logic [7:0]     i_luma,
    input  logic [7:0]     i_cb,
    input  logic [7:0]     i_cr,
    output y2r_pkg::t_px   o_px
);
    import y2r_pkg::*;

    logic signed [8:0]  e9, d9;
    logic signed [19:0] e20, d20, y20;
    logic signed [24:0] e25, d25, ys;
    logic signed [24:0] q_r, q_g, q_b;
    logic signed [19:0] s_r, s_g, s_b;
    logic signed [19:0] base, n_r, n_g, n_b;
    t_px px_q14, px_shift, px_ntsc;

    assign e9  = $signed({1'b0, i_cb}) - CHROMA_OFS;
    assign d9  = $signed({1'b0, i_cr}) - CHROMA_OFS;
    assign e20 = 20'(e9);
    assign d20 = 20'(d9);
    assign e25 = 25'(e9);
    assign d25 = 25'(d9);
    assign y20 = $signed({12'd0, i_luma});
    assign ys  = $signed({3'b000, i_luma, 14'd0});

    // Q14 coefficient form
    assign q_r = ys + d25 * Q14_RED_CR;
    assign q_g = ys - e25 * Q14_GREEN_CB - d25 * Q14_GREEN_CR;
    assign q_b = ys + e25 * Q14_BLUE_CB;

    assign px_q14.red   = q14_clip(q_r);
    assign px_q14.green = q14_clip(q_g);
    assign px_q14.blue  = q14_clip(q_b);

    // Shift-and-add approximation, arithmetic shifts floor
    assign s_r = y20 + d20 + (d20 >>> 2) + (d20 >>> 3) + (d20 >>> 5);
    assign s_g = y20 - ((e20 >>> 2) + (e20 >>> 4) + (e20 >>> 5))
                     - ((d20 >>> 1) + (d20 >>> 3) + (d20 >>> 4) + (d20 >>> 5));
    assign s_b = y20 + e20 + (e20 >>> 1) + (e20 >>> 2) + (e20 >>> 6);

    assign px_shift.red   = clip8(s_r);
    assign px_shift.green = clip8(s_g);
    assign px_shift.blue  = clip8(s_b);

    // Studio range
    assign base = NTSC_Y * (y20 - NTSC_Y_OFS) + NTSC_ROUND;
    assign n_r  = (base + NTSC_R_CR * d20) >>> 8;
    assign n_g  = (base - NTSC_G_CB * e20 - NTSC_G_CR * d20) >>> 8;
    assign n_b  = (base + NTSC_B_CB * e20) >>> 8;

    assign px_ntsc.red   = clip8(n_r);
    assign px_ntsc.green = clip8(n_g);
    assign px_ntsc.blue  = clip8(n_b);

    always_comb begin
        case (i_mode)
            MODE_ITU_SHIFT: o_px = px_shift;
            MODE_NTSC:      o_px = px_ntsc;
            default:        o_px = px_q14;
        endcase
    end

endmodule

// ===== design/y2r_out_seq.sv =====
// Output merge stage: takes both lane pixels of a group and emits them one per cycle.
module y2r_out_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  y2r_pkg::t_px  i_px0,
    input  y2r_pkg::t_px  i_px1,
    input  logic          i_frame_end,
    output logic          o_take,
    output logic          o_strobe,
    output y2r_pkg::t_px  o_px,
    output logic          o_pixel_slot,
    output logic          o_run_last,
    output logic          o_frame_last
);
    import y2r_pkg::*;

    logic r_hold;
    logic r_strobe;
    t_px  r_px1;
    logic r_fend;
    t_px  r_px;
    logic r_slot;
    logic r_run_last;
    logic r_frame_last;

    // A new pair is taken only when no second pixel is waiting.
    assign o_take = !r_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold   <= 1'b0;
            r_strobe <= 1'b0;
        end else if (r_hold) begin
            r_hold       <= 1'b0;
            r_strobe     <= 1'b1;
            r_px         <= r_px1;
            r_slot       <= 1'b1;
            r_run_last   <= 1'b1;
            r_frame_last <= r_fend;
        end else if (i_valid) begin
            r_hold       <= 1'b1;
            r_strobe     <= 1'b1;
            r_px         <= i_px0;
            r_slot       <= 1'b0;
            r_run_last   <= 1'b0;
            r_frame_last <= 1'b0;
            r_px1        <= i_px1;
            r_fend       <= i_frame_end;
        end else begin
            r_strobe <= 1'b0;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_px         = r_px;
    assign o_pixel_slot = r_slot;
    assign o_run_last   = r_run_last;
    assign o_frame_last = r_frame_last;

endmodule
